/* design/npt_pkg.sv */
// Shared constants and field widths for the neighbor presence table.
// No dependencies; imported by the top level.
package npt_pkg;

    // table geometry
    localparam int TABLE_DEPTH_DEF = 16;

    // field widths
    localparam int NOW_W   = 32;
    localparam int KEY_W   = 64;
    localparam int RSSI_W  = 9;
    localparam int BEST_W  = 11;
    localparam int ENTRY_W = KEY_W + RSSI_W + NOW_W;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((NOW_W + KEY_W + RSSI_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + BEST_W + 1 + 7) / 8) * 8;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_TIMEOUT = 1'b0;   // register index (paddr[2])

    localparam logic [NOW_W-1:0] TIMEOUT_RESET = NOW_W'(1000 * 60 * 5);

    localparam logic signed [BEST_W-1:0] NO_RSSI = -11'sd1000;

    // item kinds carried in tuser
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

/* design/npt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used by the neighbor presence table for its entry store.
module npt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/neighbor_presence_table.sv */
// Neighbor presence table: top level, control sequencer and config register.
// Depends on npt_pkg and npt_ram.
//
// Keeps up to TABLE_DEPTH radio peers (key, last RSSI, last-seen time) in one
// RAM with a registered read. A record request (tuser = 0) scans the filled
// entries for its key; on a hit the entry gets the new RSSI and time and
// newly_seen reports an age above the timeout register, on a miss the peer is
// appended (newly_seen = 1) or, with the table full, dropped with table_full.
// A query request (tuser = 1) returns the strongest RSSI of entries younger
// than the timeout, -1000 when there is none. Ages wrap modulo 2^32. Entries
// fill in order, so the fill count alone marks which ones are valid and reset
// needs no clearing pass. The scan reads one entry per cycle through the single
// RAM read port, then the finish state, once the result register is free,
// writes back and loads the result register. A finished result waits in that
// register while the next request is taken. The timeout register sits at byte
// address 0 and may only be written while no request is in flight.
module neighbor_presence_table #(
    parameter int TABLE_DEPTH = npt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: now_ms[31:0], user_key[95:32], rssi_in[104:96], zero pad
    input  logic [npt_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: op
    input  logic                          s_tuser,

    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: newly_seen[0], best_rssi[11:1], table_full[12], zero pad
    output logic [npt_pkg::M_TDATA_W-1:0] m_tdata,

    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [npt_pkg::PADDR_W-1:0]   paddr,
    input  logic [npt_pkg::PDATA_W-1:0]   pwdata,
    output logic [npt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import npt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [NOW_W-1:0] timeout_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TIMEOUT);
    assign prdata = (paddr[2] == REG_TIMEOUT) ? PDATA_W'(timeout_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= pwdata[NOW_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;     // filled entries
    logic [CW-1:0]   scan_reg, scan_next;       // next entry to read
    logic            rvalid_reg, rvalid_next;   // read data valid this cycle
    logic [IW-1:0]   ridx_reg, ridx_next;       // entry behind read data
    logic            hit_reg, hit_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;
    logic            stale_reg, stale_next;     // hit entry older than timeout
    logic signed [BEST_W-1:0] best_reg, best_next;
    logic            out_valid_reg, out_valid_next;

    // latched request
    logic             op_reg;
    logic [NOW_W-1:0] now_reg;
    logic [KEY_W-1:0] key_reg;
    logic [RSSI_W-1:0] rssi_reg;

    // result register payload
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // RAM interface
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    // read data fields
    logic [KEY_W-1:0]  rd_key;
    logic [RSSI_W-1:0] rd_rssi;
    logic [NOW_W-1:0]  rd_last;
    logic [NOW_W-1:0]  rd_age;
    logic signed [BEST_W-1:0] rd_rssi_ext;

    logic in_acc;
    logic out_free;

    assign {rd_last, rd_rssi, rd_key} = ram_rdata;
    assign rd_age      = now_reg - rd_last;
    assign rd_rssi_ext = {{(BEST_W - RSSI_W){rd_rssi[RSSI_W-1]}}, rd_rssi};

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign out_free = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // scan reads one entry per cycle until the fill count
    assign ram_re = (state_reg == ST_SCAN) && (scan_reg < count_reg);

    npt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        stale_next     = stale_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = {now_reg, rssi_reg, key_reg};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    stale_next = 1'b0;
                    best_next  = NO_RSSI;
                end
            end

            ST_SCAN:
            begin
                if (ram_re)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = scan_reg[IW-1:0];
                    scan_next   = scan_reg + CW'(1);
                end

                if (rvalid_reg)
                begin
                    if (op_reg == OP_QUERY)
                    begin
                        if ((rd_age < timeout_reg) && (rd_rssi_ext > best_reg))
                        begin
                            best_next = rd_rssi_ext;
                        end
                    end
                    else if (!hit_reg && (rd_key == key_reg))
                    begin
                        // lowest matching slot wins
                        hit_next     = 1'b1;
                        hit_idx_next = ridx_reg;
                        stale_next   = (rd_age > timeout_reg);
                    end
                end
                else if (!ram_re)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (op_reg == OP_QUERY)
                    begin
                        out_data_next = M_TDATA_W'({1'b0, best_reg, 1'b0});
                    end
                    else if (hit_reg)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = hit_idx_reg;
                        out_data_next = M_TDATA_W'({1'b0, {BEST_W{1'b0}}, stale_reg});
                    end
                    else if (count_reg < FULL_COUNT)
                    begin
                        // append in the next free slot
                        ram_we        = 1'b1;
                        ram_waddr     = count_reg[IW-1:0];
                        count_next    = count_reg + CW'(1);
                        out_data_next = M_TDATA_W'({1'b0, {BEST_W{1'b0}}, 1'b1});
                    end
                    else
                    begin
                        // table full: peer dropped
                        out_data_next = M_TDATA_W'({1'b1, {BEST_W{1'b0}}, 1'b1});
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            rvalid_reg    <= 1'b0;
            ridx_reg      <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            stale_reg     <= 1'b0;
            best_reg      <= NO_RSSI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rvalid_reg    <= rvalid_next;
            ridx_reg      <= ridx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            stale_reg     <= stale_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= s_tuser;
            now_reg  <= s_tdata[NOW_W-1:0];
            key_reg  <= s_tdata[NOW_W +: KEY_W];
            rssi_reg <= s_tdata[NOW_W + KEY_W +: RSSI_W];
        end
        out_data_reg <= out_data_next;
    end

endmodule

/* test/neighbor_presence_table_tb.sv */
// Self-checking testbench for the neighbor presence table.
// Needs npt_pkg and neighbor_presence_table; reads no files.
`timescale 1ns / 100ps

// one reply from the result stream, unpacked
typedef struct packed {
    logic                                    newly_seen;
    logic signed [npt_pkg::BEST_W-1:0]       best_rssi;
    logic                                    table_full;
} peer_reply_t;

// Peer table shadow: mirrors the block's entries and timeout, predicts the
// reply of each accepted request and checks replies in order.
class presence_scoreboard;
    logic [npt_pkg::NOW_W-1:0]         timeout_ms;
    logic [npt_pkg::KEY_W-1:0]         slot_key[npt_pkg::TABLE_DEPTH_DEF];
    logic signed [npt_pkg::RSSI_W-1:0] slot_rssi[npt_pkg::TABLE_DEPTH_DEF];
    logic [npt_pkg::NOW_W-1:0]         slot_last_seen[npt_pkg::TABLE_DEPTH_DEF];
    int                                filled;
    peer_reply_t                       pending_replies[$];
    int                                mismatches;
    int                                n_query;
    int                                n_record;
    int                                n_dropped;
    int                                n_fresh;

    function new();
        timeout_ms = npt_pkg::TIMEOUT_RESET;
        filled     = 0;
        mismatches = 0;
        n_query    = 0;
        n_record   = 0;
        n_dropped  = 0;
        n_fresh    = 0;
    endfunction

    task report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // predict the reply to one accepted request and update the shadow table
    function void log_request(input logic op, input logic [npt_pkg::NOW_W-1:0] now,
                              input logic [npt_pkg::KEY_W-1:0] key,
                              input logic signed [npt_pkg::RSSI_W-1:0] rssi);
        peer_reply_t               r;
        int                        best;
        int                        hit;
        logic [npt_pkg::NOW_W-1:0] age;
        r    = '0;
        best = -1000;
        hit  = -1;
        if (op == npt_pkg::OP_QUERY)
        begin
            n_query++;
            for (int i = 0; i < filled; i++)
            begin
                age = now - slot_last_seen[i];
                if (int'(slot_rssi[i]) > best && age < timeout_ms)
                    best = slot_rssi[i];
            end
            r.best_rssi = best[npt_pkg::BEST_W-1:0];
        end
        else
        begin
            n_record++;
            for (int i = 0; i < filled; i++)
                if (hit < 0 && slot_key[i] == key)
                    hit = i;
            if (hit >= 0)
            begin
                age = now - slot_last_seen[hit];
                slot_rssi[hit]      = rssi;
                slot_last_seen[hit] = now;
                r.newly_seen        = (age > timeout_ms);
            end
            else
            begin
                r.newly_seen = 1'b1;
                if (filled < npt_pkg::TABLE_DEPTH_DEF)
                begin
                    slot_key[filled]       = key;
                    slot_rssi[filled]      = rssi;
                    slot_last_seen[filled] = now;
                    filled++;
                end
                else
                begin
                    r.table_full = 1'b1;
                    n_dropped++;
                end
            end
            if (r.newly_seen)
                n_fresh++;
        end
        pending_replies = {pending_replies, r};
    endfunction

    task check_reply(input logic [npt_pkg::M_TDATA_W-1:0] tdata);
        peer_reply_t want;
        peer_reply_t got;
        got.newly_seen = tdata[0];
        got.best_rssi  = tdata[npt_pkg::BEST_W:1];
        got.table_full = tdata[npt_pkg::BEST_W+1];
        if (pending_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply %h with no request outstanding", tdata));
        end
        else
        begin
            want = pending_replies.pop_front();
            if (got.newly_seen !== want.newly_seen)
                report_mismatch($sformatf("newly_seen %b, want %b",
                                          got.newly_seen, want.newly_seen));
            if (got.best_rssi !== want.best_rssi)
                report_mismatch($sformatf("best_rssi %0d, want %0d",
                                          got.best_rssi, want.best_rssi));
            if (got.table_full !== want.table_full)
                report_mismatch($sformatf("table_full %b, want %b",
                                          got.table_full, want.table_full));
        end
    endtask
endclass

module neighbor_presence_table_tb;
    import npt_pkg::*;

    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 222;
    localparam int POOL_SIZE     = 20;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH_DEF + 8;

    // directed keys: all zeros, all ones, a short packed name
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_NAME = 64'h0000_0065_6369_6c61;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    presence_scoreboard   sb;

    // idle percentages per stream side, changed between phases
    int                   sender_idle_pct;
    int                   receiver_idle_pct;
    int                   n_settings;
    logic [NOW_W-1:0]     cur_now;
    logic [KEY_W-1:0]     key_pool[POOL_SIZE];

    neighbor_presence_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock, rising edge at 5 ns
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: ready toggles on the falling edge, replies checked on the rising edge
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata);
    end

    // Push one request. Optional idle cycles first, then hold valid until the
    // block takes it; the shadow table is updated at the accepting edge.
    task send_request(input logic op, input logic [NOW_W-1:0] now,
                      input logic [KEY_W-1:0] key, input logic signed [RSSI_W-1:0] rssi);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = '0;
        s_tdata[NOW_W-1:0]                         = now;
        s_tdata[NOW_W+KEY_W-1:NOW_W]               = key;
        s_tdata[NOW_W+KEY_W+RSSI_W-1:NOW_W+KEY_W]  = rssi;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.log_request(op, now, key, rssi);
    endtask

    task wait_for_replies();
        int n;
        n = 0;
        while (sb.pending_replies.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Set the timeout over APB once the block has nothing in flight, then
    // read it back.
    task set_timeout(input logic [NOW_W-1:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_for_replies();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'({REG_TIMEOUT, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.timeout_ms = value;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            sb.report_mismatch($sformatf("timeout read back %h, want %h", prdata, value));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        n_settings++;
    endtask

    function automatic logic signed [RSSI_W-1:0] pick_rssi();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return -9'sd255;
        else if (r < 10)
            return 9'sd255;
        return RSSI_W'($urandom_range(510) - 255);
    endfunction

    // One random request. Most times walk forward by a fraction of the
    // timeout; some land right at the age boundary of a stored peer, some
    // jump anywhere, some repeat the last time.
    task send_random_request();
        logic             op;
        logic [NOW_W-1:0] now;
        logic [KEY_W-1:0] key;
        logic [NOW_W-1:0] step;
        int               r;
        int               slot;
        op   = ($urandom_range(99) < 30) ? OP_QUERY : OP_RECORD;
        key  = key_pool[$urandom_range(POOL_SIZE-1)];
        step = (sb.timeout_ms >> 3) + 3;
        r    = $urandom_range(99);
        if (r < 50)
        begin
            cur_now = cur_now + NOW_W'($urandom_range(step));
        end
        else if (r < 75 && sb.filled > 0)
        begin
            // age of timeout - 1, timeout or timeout + 1 for one stored peer
            slot    = $urandom_range(sb.filled - 1);
            cur_now = sb.slot_last_seen[slot] + sb.timeout_ms + $urandom_range(2) - 1;
            if ($urandom_range(9) < 7)
                key = sb.slot_key[slot];
        end
        else if (r < 85)
        begin
            cur_now = $urandom;
        end
        now = cur_now;
        // occasional unknown peer, dropped once the table is full
        if ($urandom_range(99) < 6)
            key = {$urandom, $urandom};
        send_request(op, now, key, pick_rssi());
    endtask

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [NOW_W-1:0] phase_timeout[N_PHASES];

        sb                = new();
        n_settings        = 0;
        sender_idle_pct   = 14;
        receiver_idle_pct = 46;
        cur_now           = '0;
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tuser           = OP_RECORD;
        s_tdata           = '0;
        m_tready          = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        // key pool: the directed keys plus random peers, more than fit
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        key_pool[2] = KEY_NAME;
        for (int i = 3; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        phase_timeout[0] = TIMEOUT_RESET;
        phase_timeout[1] = 32'd1;
        phase_timeout[2] = '1;
        phase_timeout[3] = '0;
        phase_timeout[4] = $urandom;
        phase_timeout[5] = 32'd5000;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: reset timeout ---
        send_request(OP_QUERY,  32'd0,         KEY_ZERO, 9'sd0);   // empty table
        send_request(OP_RECORD, 32'd0,         KEY_ZERO, -9'sd255);
        send_request(OP_RECORD, 32'd100,       KEY_ONES, 9'sd255);
        send_request(OP_RECORD, 32'd200,       KEY_NAME, 9'sd0);
        send_request(OP_QUERY,  32'd300,       KEY_ONES, -9'sd1);
        send_request(OP_RECORD, 32'd300000,    KEY_ZERO, -9'sd1);  // age equals timeout
        send_request(OP_RECORD, 32'd300101,    KEY_ONES, 9'sd7);   // one past timeout
        send_request(OP_QUERY,  32'd600000,    KEY_NAME, 9'sd0);   // age at timeout not recent
        send_request(OP_RECORD, 32'hFFFF_FF00, KEY_NAME, 9'sd12);
        send_request(OP_QUERY,  32'h0000_0010, KEY_ZERO, 9'sd0);   // ages wrap past zero

        // --- directed: shortest timeout ---
        set_timeout(32'd1);
        send_request(OP_RECORD, 32'hFFFF_FF00, KEY_NAME, 9'sd1);   // age zero
        send_request(OP_RECORD, 32'hFFFF_FF01, KEY_NAME, 9'sd2);   // age equals timeout
        send_request(OP_RECORD, 32'hFFFF_FF03, KEY_NAME, 9'sd3);   // newly seen again
        send_request(OP_QUERY,  32'hFFFF_FF03, KEY_NAME, 9'sd0);
        send_request(OP_QUERY,  32'hFFFF_FF04, KEY_NAME, 9'sd0);

        // --- directed: zero timeout, nothing counts as recent ---
        set_timeout(32'd0);
        send_request(OP_RECORD, 32'hFFFF_FF03, KEY_NAME, -9'sd5);
        send_request(OP_RECORD, 32'hFFFF_FF04, KEY_NAME, -9'sd6);
        send_request(OP_QUERY,  32'hFFFF_FF04, KEY_NAME, 9'sd0);

        // --- directed: largest timeout ---
        set_timeout('1);
        send_request(OP_QUERY,  32'h0000_1234, KEY_ZERO, 9'sd0);
        send_request(OP_RECORD, 32'd299999,    KEY_ZERO, 9'sd100); // age equals timeout

        // --- random phases: two per idle pattern ---
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    sender_idle_pct   = 14;
                    receiver_idle_pct = 46;
                end
                1:
                begin
                    sender_idle_pct   = 46;
                    receiver_idle_pct = 14;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            set_timeout(phase_timeout[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_request();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_replies.size() != 0)
            sb.report_mismatch($sformatf("%0d replies never arrived",
                                         sb.pending_replies.size()));

        $display("Ran %0d records and %0d queries across %0d timeout settings.",
                 sb.n_record, sb.n_query, n_settings);
        $display("%0d sightings flagged newly seen, %0d peers dropped on a full table.",
                 sb.n_fresh, sb.n_dropped);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
